[src/scfla_pkg.sv]
// Shared types and constants for the size-class free-list allocator.
// Field widths, status and register codes, controller/datapath structs.
// No dependencies.
package scfla_pkg;

   localparam int REQ_SIZE_W  = 24;
   localparam int ADDR_W      = 21;
   localparam int SIZE_W      = 25;
   localparam int HEAD_W      = 20;
   localparam int PAGE_W      = 17;
   localparam int LIMIT_W     = 15;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 21;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 48;

   // pooled sizes never reach this, whatever small_limit says
   localparam int SMALL_CAP   = 16 * 1024;
   // candidate classes examined by the size encoder
   localparam int CAND_N      = 16;
   localparam int CAND_W      = 4;
   localparam int CSIZE_W     = 16;
   // remainder unit
   localparam int DIV_W       = SIZE_W;
   localparam int DIV_CNT_W   = 5;

   localparam logic [PAGE_W-1:0]  PAGE_RESET  = PAGE_W'(4096);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
   localparam logic [ADDR_W-1:0]  START_RESET = ADDR_W'(4096);
   localparam logic [ADDR_W-1:0]  END_RESET   = ADDR_W'(1048576);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_ALLOC      = 3'd0,
      ST_ZERO       = 3'd1,
      ST_LARGE      = 3'd2,
      ST_NOSPACE    = 3'd3,
      ST_FREED      = 3'd4,
      ST_LARGE_FREE = 3'd5,
      ST_NULL_FREE  = 3'd6
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAGE_BYTES  = 2'd0,
      REG_SMALL_LIMIT = 2'd1,
      REG_ARENA_START = 2'd2,
      REG_ARENA_END   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic commit_exec;
      logic link_rd;
      logic commit_pop;
      logic div_start;
      logic commit_large;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic pop;
      logic div_busy;
   } dp_status_type;

endpackage

[src/scfla_rem.sv]
// Restoring remainder unit, one dividend bit per cycle.
// Used for page rounding of large sizes. Depends on scfla_pkg.
module scfla_rem
   import scfla_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [PAGE_W-1:0] divisor,
   output logic              busy,
   output logic [PAGE_W-1:0] remainder
);

   logic [PAGE_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [PAGE_W:0]      trial;
   logic [PAGE_W:0]      diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = (trial >= {1'b0, divisor}) ? diff[PAGE_W-1:0] : trial[PAGE_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], 1'b0};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

[src/scfla_dp.sv]
// Allocator datapath: configuration registers, size classing, list heads,
// link memory, bump pointer and result register. Depends on scfla_pkg, scfla_rem.
module scfla_dp
   import scfla_pkg::*;
#(
   parameter int ARENA_BYTES  = 1048576,
   parameter int NUM_CLASSES  = 12,
   parameter int MIN_BLOCK    = 8,
   parameter int HEADER_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  req_action,
   input  logic [REQ_SIZE_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0]     req_user_address,
   input  logic [SIZE_W-1:0]     req_stored_size,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [2:0]            rsp_status,
   output logic [ADDR_W-1:0]     rsp_result_address,
   output logic [SIZE_W-1:0]     rsp_block_size
);

   // MIN_BLOCK and ARENA_BYTES are powers of two
   localparam int LINK_DEPTH = ARENA_BYTES / MIN_BLOCK;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);
   localparam int MIN_SH     = $clog2(MIN_BLOCK);
   localparam int CLS_AW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   // configuration
   logic [PAGE_W-1:0]  page_bytes_ff;
   logic [LIMIT_W-1:0] small_limit_ff;
   logic [ADDR_W-1:0]  arena_start_ff;
   logic [ADDR_W-1:0]  arena_end_ff;

   // state
   logic [HEAD_W-1:0]  heads_ff [NUM_CLASSES];
   logic [ADDR_W-1:0]  bump_ff;
   logic [HEAD_W-1:0]  link_mem [LINK_DEPTH];
   logic [HEAD_W-1:0]  link_q_ff;

   // captured request
   logic               act_ff;
   logic               special_ff;
   logic               ge_lim_ff;
   logic               small_ff;
   logic [CAND_W-1:0]  cls_ff;
   logic [CSIZE_W-1:0] csize_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [HEAD_W-1:0]  block_ff;

   // results
   status_type         status_ff, status_in;
   logic [ADDR_W-1:0]  raddr_ff, raddr_in;
   logic [SIZE_W-1:0]  bsize_ff, bsize_in;

   logic [SIZE_W-1:0]  sum_req;
   logic [SIZE_W-1:0]  size_c;
   logic [LIMIT_W-1:0] eff_lim;
   logic [CAND_N-1:0]  cand_ge;
   logic [CAND_W-1:0]  cls_c;
   logic [31:0]        cand_sel;
   logic               small_c;

   logic [CLS_AW-1:0]  hidx;
   logic [HEAD_W-1:0]  head_q;
   logic [31:0]        push_wide;
   logic [31:0]        pop_wide;
   logic [LINK_AW-1:0] push_idx;
   logic [LINK_AW-1:0] pop_idx;
   logic [ADDR_W:0]    bump_sum;
   logic               nospace;
   logic [PAGE_W-1:0]  rem;
   logic               rem_busy;
   logic [SIZE_W:0]    page_up;

   // ---- classing of the incoming request
   always_comb begin
      sum_req = {1'b0, req_request_size} + SIZE_W'(HEADER_BYTES);
      size_c  = (req_action == ACT_FREE) ? req_stored_size : sum_req;
      eff_lim = (small_limit_ff > LIMIT_W'(SMALL_CAP)) ? LIMIT_W'(SMALL_CAP) : small_limit_ff;
      for (int k = 0; k < CAND_N; k++) begin
         cand_ge[k] = ((32'(MIN_BLOCK) << k) >= {7'd0, size_c});
      end
      // thermometer code: lowest set bit is the class
      cls_c = '0;
      for (int k = CAND_N - 1; k >= 0; k--) begin
         if (cand_ge[k]) begin
            cls_c = CAND_W'(k);
         end
      end
      cand_sel = 32'(MIN_BLOCK) << cls_c;
      small_c  = (cand_sel < 32'(eff_lim)) &&
                 ({1'b0, cls_c} < (CAND_W + 1)'(NUM_CLASSES));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff     <= req_action;
         special_ff <= (req_action == ACT_FREE) ? (req_user_address == '0)
                                                : (req_request_size == '0);
         ge_lim_ff  <= (size_c >= SIZE_W'(eff_lim));
         small_ff   <= small_c;
         cls_ff     <= cls_c;
         csize_ff   <= cand_sel[CSIZE_W-1:0];
         size_ff    <= size_c;
         block_ff   <= HEAD_W'(req_user_address - ADDR_W'(HEADER_BYTES));
      end
   end

   // ---- list access
   assign hidx      = cls_ff[CLS_AW-1:0];
   assign head_q    = heads_ff[hidx];
   assign push_wide = 32'(block_ff) >> MIN_SH;
   assign pop_wide  = 32'(head_q) >> MIN_SH;
   assign push_idx  = push_wide[LINK_AW-1:0];
   assign pop_idx   = pop_wide[LINK_AW-1:0];
   assign bump_sum  = {1'b0, bump_ff} + (ADDR_W + 1)'(csize_ff);
   assign nospace   = bump_sum > {1'b0, arena_end_ff};

   assign status.needs_div = !special_ff && ge_lim_ff;
   assign status.pop       = (act_ff == ACT_ALLOC) && !special_ff && !ge_lim_ff &&
                             small_ff && (head_q != '0);
   assign status.div_busy  = rem_busy;

   always_ff @(posedge clock) begin
      if (cmd.commit_exec && !special_ff && !ge_lim_ff && small_ff && act_ff == ACT_FREE) begin
         link_mem[push_idx] <= head_q;
      end
      if (cmd.link_rd) begin
         link_q_ff <= link_mem[pop_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_bytes_ff  <= PAGE_RESET;
         small_limit_ff <= LIMIT_RESET;
         arena_start_ff <= START_RESET;
         arena_end_ff   <= END_RESET;
         bump_ff        <= START_RESET;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               REG_PAGE_BYTES:  page_bytes_ff  <= csr_data[PAGE_W-1:0];
               REG_SMALL_LIMIT: small_limit_ff <= csr_data[LIMIT_W-1:0];
               REG_ARENA_START: begin
                  arena_start_ff <= csr_data;
                  bump_ff        <= csr_data;
               end
               REG_ARENA_END:   arena_end_ff   <= csr_data;
               default: ;
            endcase
         end
         if (cmd.commit_exec && !special_ff && !ge_lim_ff && small_ff) begin
            if (act_ff == ACT_FREE) begin
               heads_ff[hidx] <= block_ff;
            end else if (!nospace) begin
               bump_ff <= bump_sum[ADDR_W-1:0];
            end
         end
         if (cmd.commit_pop) begin
            heads_ff[hidx] <= link_q_ff;
         end
      end
   end

   // ---- page rounding
   scfla_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (size_ff),
      .divisor   (page_bytes_ff),
      .busy      (rem_busy),
      .remainder (rem)
   );

   assign page_up = {1'b0, size_ff} + (SIZE_W + 1)'(page_bytes_ff) - (SIZE_W + 1)'(rem);

   // ---- result register
   always_comb begin
      status_in = status_ff;
      raddr_in  = raddr_ff;
      bsize_in  = bsize_ff;
      if (cmd.commit_exec) begin
         raddr_in = '0;
         bsize_in = SIZE_W'(csize_ff);
         if (special_ff) begin
            status_in = (act_ff == ACT_FREE) ? ST_NULL_FREE : ST_ZERO;
            bsize_in  = '0;
         end else if (!small_ff) begin
            // class reached the limit or ran out of classes
            status_in = (act_ff == ACT_FREE) ? ST_LARGE_FREE : ST_LARGE;
         end else if (act_ff == ACT_FREE) begin
            status_in = ST_FREED;
         end else if (nospace) begin
            status_in = ST_NOSPACE;
         end else begin
            status_in = ST_ALLOC;
            raddr_in  = bump_ff + ADDR_W'(HEADER_BYTES);
         end
      end else if (cmd.commit_pop) begin
         status_in = ST_ALLOC;
         raddr_in  = ADDR_W'(head_q) + ADDR_W'(HEADER_BYTES);
         bsize_in  = SIZE_W'(csize_ff);
      end else if (cmd.commit_large) begin
         status_in = (act_ff == ACT_FREE) ? ST_LARGE_FREE : ST_LARGE;
         raddr_in  = '0;
         if (page_bytes_ff == '0 || rem == '0) begin
            bsize_in = size_ff;
         end else begin
            bsize_in = page_up[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      raddr_ff  <= raddr_in;
      bsize_ff  <= bsize_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_result_address = raddr_ff;
   assign rsp_block_size     = bsize_ff;

endmodule

[src/scfla_ctrl.sv]
// Allocator sequencer: request acceptance, operation steps, result valid.
// Drives the datapath by command struct. Depends on scfla_pkg.
module scfla_ctrl
   import scfla_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP,
      S_DIV,
      S_LDONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.needs_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.pop) begin
               cmd.link_rd = 1'b1;
               state_in    = S_POP;
            end else if (out_free) begin
               cmd.commit_exec = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               cmd.commit_pop = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_DIV: begin
            if (!status.div_busy) begin
               state_in = S_LDONE;
            end
         end
         S_LDONE: begin
            if (out_free) begin
               cmd.commit_large = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.commit_exec || cmd.commit_pop || cmd.commit_large) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

[src/size_class_free_list_allocator_core.sv]
// Top level of the size-class free-list allocator.
// Depends on scfla_pkg, scfla_ctrl, scfla_dp (and scfla_rem below it).
//
// Usage:
//   req_*  : one allocate or free request per transaction; req_tuser is the
//            action (0 allocate, 1 free).
//   rsp_*  : one result per request, in order; rsp_tuser is the status.
//   csr_*  : register writes (page_bytes, small_limit, arena_start,
//            arena_end), always ready; write only while no request is open.
//            Writing arena_start also reloads the bump pointer.
// Steps, from acceptance to the result in the output register:
//   bump allocation, free, or a flagged request: S_EXEC loads the result
//   pop from a non-empty list: S_EXEC starts the link memory read, then S_POP
//   large request rounded to pages: S_EXEC, S_DIV (25-step remainder unit), S_LDONE
// One request is in flight at a time; req_tready returns high once the result
// has been loaded. A stalled receiver holds the result register and the next
// result waits until it is taken.
// Reset restores the register defaults, empties every class list and sets
// the bump pointer to arena_start; the link memory needs no clearing.
module size_class_free_list_allocator_core
   import scfla_pkg::*;
#(
   parameter int ARENA_BYTES  = 1048576,
   parameter int NUM_CLASSES  = 12,
   parameter int MIN_BLOCK    = 8,
   parameter int HEADER_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // request_size [23:0], user_address [44:24], stored_size [69:45]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action [0]
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result_address [20:0], block_size [45:21]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status [2:0]
   output logic [2:0]             rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type        cmd;
   dp_status_type     dp_status;
   logic [ADDR_W-1:0] result_address;
   logic [SIZE_W-1:0] block_size;

   assign csr_ready = 1'b1;

   scfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   scfla_dp #(
      .ARENA_BYTES  (ARENA_BYTES),
      .NUM_CLASSES  (NUM_CLASSES),
      .MIN_BLOCK    (MIN_BLOCK),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (dp_status),
      .req_action         (req_tuser[0]),
      .req_request_size   (req_tdata[23:0]),
      .req_user_address   (req_tdata[44:24]),
      .req_stored_size    (req_tdata[69:45]),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_status         (rsp_tuser),
      .rsp_result_address (result_address),
      .rsp_block_size     (block_size)
   );

   assign rsp_tdata = {2'b00, block_size, result_address};

endmodule

[src/scfla_checker.sv]
// Port-level checks for the allocator top level, attached by bind.
// Depends on scfla_pkg and size_class_free_list_allocator_core.
module scfla_checker
   import scfla_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]             rsp_tuser
);

   // a waiting result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one request at a time
   a_one_open: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is open");

   // only a successful allocation carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_ALLOC |-> rsp_tdata[20:0] == '0)
      else $error("address on a non-allocation result");

   // zero-size and null-free results are empty
   a_flagged_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_ZERO || rsp_tuser == ST_NULL_FREE)
      |-> rsp_tdata == '0)
      else $error("flagged result carries data");

endmodule

bind size_class_free_list_allocator_core scfla_checker u_scfla_checker (.*);

[tb/size_class_free_list_allocator_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for size_class_free_list_allocator_core: allocate and free traffic
// with random idling on both streams, checked against an allocator model kept in the bench.
// Depends on scfla_pkg and the allocator RTL only.
module size_class_free_list_allocator_core_test
   import scfla_pkg::*;
();

   localparam int HDR        = 8;
   localparam int MIN_BLK    = 8;
   localparam int NCLASS     = 12;
   localparam int LINK_DEPTH = 1048576 / MIN_BLK;
   localparam longint unsigned MASK25 = 64'h1FF_FFFF;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic        act;
      logic [23:0] req_size;
      logic [20:0] uaddr;
      logic [24:0] stored;
   } request_item_type;

   typedef struct packed {
      status_type  status;
      logic [20:0] addr;
      logic [24:0] size;
   } outcome_type;

   typedef struct packed {
      logic [20:0] addr;
      logic [24:0] size;
   } live_block_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = REG_PAGE_BYTES;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow of the allocator
   longint unsigned page_sz, limit_sz, start_addr, end_addr, bump_ptr;
   logic [19:0]     class_head [NCLASS];
   logic [19:0]     next_link [LINK_DEPTH];

   request_item_type request_queue [$];
   outcome_type      awaited_results [$];
   live_block_type   live_blocks [$];
   request_item_type cur_req;

   int fault_count = 0;
   int accepted_n = 0;
   int results_n = 0;
   int pops_n = 0;
   int settings_n = 0;
   int status_seen [8];
   bit no_idle = 1'b0;
   bit req_fired = 1'b0;
   int send_gap = 0;
   int stall_left = 0;

   size_class_free_list_allocator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned round_to_page(longint unsigned sz);
      if (page_sz == 0) return sz & MASK25;
      return (((sz + page_sz - 1) / page_sz) * page_sz) & MASK25;
   endfunction

   // 1 when the size is pooled; csz is the class size (or page-rounded when it reaches the limit)
   function automatic bit size_class(input longint unsigned sz,
                                     output longint unsigned csz, output int cidx);
      longint unsigned lim;
      longint unsigned s;
      lim = (limit_sz < SMALL_CAP) ? limit_sz : SMALL_CAP;
      s = MIN_BLK;
      cidx = 0;
      if (sz >= lim) begin
         csz = round_to_page(sz);
         return 1'b0;
      end
      while (s < sz) begin
         s = s << 1;
         cidx++;
      end
      csz = s & MASK25;
      return (s < lim) && (cidx < NCLASS);
   endfunction

   function automatic outcome_type allocator_outcome(request_item_type r);
      outcome_type     o;
      longint unsigned csz;
      longint unsigned blk;
      int              c;
      bit              pooled;
      o.status = ST_ALLOC;
      o.addr = '0;
      o.size = '0;
      if (r.act == ACT_ALLOC) begin
         if (r.req_size == 0) begin
            o.status = ST_ZERO;
         end else begin
            pooled = size_class(longint'(r.req_size) + HDR, csz, c);
            o.size = csz[24:0];
            if (!pooled) begin
               o.status = ST_LARGE;
            end else if (class_head[c] != 0) begin
               blk = class_head[c];
               class_head[c] = next_link[blk[19:3]];
               o.addr = 21'((blk + HDR) & 64'h1F_FFFF);
               pops_n++;
               live_blocks.push_back({o.addr, o.size});
            end else if (bump_ptr + csz > end_addr) begin
               o.status = ST_NOSPACE;
            end else begin
               blk = bump_ptr;
               bump_ptr = (bump_ptr + csz) & 64'h1F_FFFF;
               o.addr = 21'((blk + HDR) & 64'h1F_FFFF);
               live_blocks.push_back({o.addr, o.size});
            end
         end
      end else begin
         if (r.uaddr == 0) begin
            o.status = ST_NULL_FREE;
         end else begin
            pooled = size_class(longint'(r.stored), csz, c);
            o.size = csz[24:0];
            if (!pooled) begin
               o.status = ST_LARGE_FREE;
            end else begin
               // addresses below the header wrap within 20 bits
               blk = (longint'(r.uaddr) - HDR) & 64'hF_FFFF;
               next_link[blk[19:3]] = class_head[c];
               class_head[c] = blk[19:0];
               o.status = ST_FREED;
            end
         end
      end
      return o;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
   endtask

   // request sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            cur_req = request_queue.pop_front();
            req_tdata <= {2'b00, cur_req.stored, cur_req.uaddr, cur_req.req_size};
            req_tuser <= cur_req.act;
            req_tvalid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
         req_fired = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         awaited_results.push_back(allocator_outcome(cur_req));
         accepted_n++;
         req_fired = 1'b1;
      end
   end

   // result receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_n++;
         status_seen[rsp_tuser]++;
         if (awaited_results.size() == 0) begin
            note_fault($sformatf("result with none pending: status %0d addr 0x%0h size %0d",
                                 rsp_tuser, rsp_tdata[20:0], rsp_tdata[45:21]));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[20:0] !== want.addr ||
                rsp_tdata[45:21] !== want.size)
               note_fault($sformatf(
                  "expected status %0d addr 0x%0h size %0d, got status %0d addr 0x%0h size %0d",
                  want.status, want.addr, want.size,
                  rsp_tuser, rsp_tdata[20:0], rsp_tdata[45:21]));
         end
      end
   end

   task automatic queue_alloc(int unsigned sz);
      request_item_type it;
      it.act = ACT_ALLOC;
      it.req_size = 24'(sz);
      it.uaddr = 21'($urandom_range(0, 1048576));
      it.stored = 25'($urandom_range(0, 16777216));
      request_queue.push_back(it);
   endtask

   task automatic queue_free(int unsigned ua, int unsigned st);
      request_item_type it;
      it.act = ACT_FREE;
      it.req_size = 24'($urandom);
      it.uaddr = 21'(ua);
      it.stored = 25'(st);
      request_queue.push_back(it);
   endtask

   // mostly allocations and frees of live blocks, the rest odd requests
   task automatic queue_random_request();
      request_item_type it;
      live_block_type   b;
      int               r, k, e;
      it.act = ACT_ALLOC;
      it.req_size = 24'($urandom);
      it.uaddr = 21'($urandom_range(0, 1048576));
      it.stored = 25'($urandom_range(0, 16777216));
      r = $urandom_range(0, 99);
      if (r < 50) begin
         e = $urandom_range(0, 13);
         it.req_size = 24'($urandom_range(1, 1 << e));
      end else if (r < 85 && live_blocks.size() != 0) begin
         k = $urandom_range(0, live_blocks.size() - 1);
         b = live_blocks[k];
         // leaving it in the pool now and then gives double frees
         if ($urandom_range(0, 9) != 0) live_blocks.delete(k);
         it.act = ACT_FREE;
         it.uaddr = b.addr;
         it.stored = b.size;
         if ($urandom_range(0, 19) == 0) it.stored = 25'($urandom_range(0, 512));
      end else begin
         case ($urandom_range(0, 4))
            0: it.req_size = '0;
            1: it.act = ACT_ALLOC;
            2: begin
               it.act = ACT_FREE;
               it.uaddr = '0;
            end
            3: begin
               it.act = ACT_FREE;
               it.stored = 25'($urandom_range(0, 1024));
            end
            default: it.act = ACT_FREE;
         endcase
      end
      request_queue.push_back(it);
   endtask

   task automatic settle();
      while (request_queue.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         while (request_queue.size() >= 2) @(posedge clock);
         queue_random_request();
         if ($urandom_range(0, 79) == 0) no_idle = !no_idle;
      end
      settle();
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PAGE_BYTES:  page_sz = val & 32'h1_FFFF;
         REG_SMALL_LIMIT: limit_sz = val & 32'h7FFF;
         REG_ARENA_START: begin
            start_addr = val & 32'h1F_FFFF;
            bump_ptr = start_addr;
         end
         default:         end_addr = val & 32'h1F_FFFF;
      endcase
   endtask

   task automatic program_regs(int unsigned page, int unsigned limit,
                               int unsigned lo, int unsigned hi);
      write_reg(REG_PAGE_BYTES, page);
      write_reg(REG_SMALL_LIMIT, limit);
      write_reg(REG_ARENA_START, lo);
      write_reg(REG_ARENA_END, hi);
      @(negedge clock) csr_valid <= 1'b0;
      settings_n++;
   endtask

   initial begin
      page_sz = PAGE_RESET;
      limit_sz = LIMIT_RESET;
      start_addr = START_RESET;
      end_addr = END_RESET;
      bump_ptr = START_RESET;
      foreach (class_head[i]) class_head[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      settings_n = 1;

      // reset settings: limit 4096, page 4096, arena from 4096
      queue_alloc(0);
      queue_alloc(1);
      queue_alloc(8);
      queue_alloc(4087);            // class reaches the limit
      queue_alloc(4088);
      queue_alloc(5000);
      queue_alloc(24'hFF_FFFF);
      queue_free(0, 16);
      queue_free(4104, 16);
      queue_alloc(1);               // pops the block just freed
      queue_free(8, 8);             // block zero: list reads empty afterwards
      queue_free(3, 32);            // below the header, wraps
      queue_alloc(20);
      queue_free(1048576, 64);
      queue_alloc(50);
      queue_free(5000, 4096);
      queue_free(5000, 16777216);
      queue_free(4200, 0);
      queue_free(4120, 16);
      queue_free(4120, 16);         // double free
      queue_alloc(1);
      queue_alloc(1);
      queue_free(4201, 1);
      queue_alloc(1016);
      settle();
      run_random(300);

      program_regs(65536, 16384, 8, 1048576);
      run_random(300);
      // non-power-of-two page, small arena that runs out
      program_regs(3000, 1000, 32'h8_0000, 32'h8_2000);
      run_random(250);
      // page 0 leaves large sizes unrounded; start past end, so no bump space
      program_regs(0, 16384, 1048576, 8);
      run_random(100);
      program_regs(8, 8, 64, 4096);
      run_random(50);
      program_regs(8, 256, 64, 4096);
      run_random(200);

      repeat (40) @(posedge clock);
      $display("%0d requests over %0d register settings, %0d list pops, %0d results checked",
               accepted_n, settings_n, pops_n, results_n);
      $display("status mix: alloc %0d, zero %0d, large %0d, no space %0d, freed %0d, %0s %0d, %0s %0d",
               status_seen[ST_ALLOC], status_seen[ST_ZERO], status_seen[ST_LARGE],
               status_seen[ST_NOSPACE], status_seen[ST_FREED], "large free",
               status_seen[ST_LARGE_FREE], "null free", status_seen[ST_NULL_FREE]);
      if (fault_count == 0)
         $display("size_class_free_list_allocator_core_test: done, clean");
      else
         $display("size_class_free_list_allocator_core_test: done, errors");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("size_class_free_list_allocator_core_test: done, errors");
      $finish;
   end

endmodule
